// ===== sv/qsld_pkg.sv =====
// ----------------------------------------------------------------------------
// qsld_pkg
// Shared types, constants and dequantizer tables of the QOA slice decoder.
// ----------------------------------------------------------------------------
package qsld_pkg;

	localparam int ROW_W         = 64;
	localparam int SLICE_SAMPLES = 20;
	localparam int ACC_W         = 34;
	localparam int PRED_SHIFT    = 13;
	localparam int SAMPLE_MIN    = -32768;
	localparam int SAMPLE_MAX    = 32767;

	localparam logic [1:0] MODE_HIST = 2'd0;
	localparam logic [1:0] MODE_WGT  = 2'd1;
	localparam logic [1:0] MODE_DEC  = 2'd2;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic clr;
		logic mul;
		logic add;
	} mac_ctl_t;

	function automatic logic [11:0] sf_lookup(input logic [3:0] sfi);
		logic [11:0] sf;
		case (sfi)
			4'd0:    sf = 12'd1;
			4'd1:    sf = 12'd7;
			4'd2:    sf = 12'd21;
			4'd3:    sf = 12'd45;
			4'd4:    sf = 12'd84;
			4'd5:    sf = 12'd138;
			4'd6:    sf = 12'd211;
			4'd7:    sf = 12'd304;
			4'd8:    sf = 12'd421;
			4'd9:    sf = 12'd562;
			4'd10:   sf = 12'd731;
			4'd11:   sf = 12'd928;
			4'd12:   sf = 12'd1157;
			4'd13:   sf = 12'd1419;
			4'd14:   sf = 12'd1715;
			default: sf = 12'd2048;
		endcase
		return sf;
	endfunction

	function automatic logic [4:0] quarter_mult(input logic [1:0] sel);
		logic [4:0] k;
		case (sel)
			2'd0:    k = 5'd3;
			2'd1:    k = 5'd10;
			2'd2:    k = 5'd18;
			default: k = 5'd28;
		endcase
		return k;
	endfunction

	function automatic logic signed [15:0] dequant(input logic [3:0] sfi, input logic [2:0] code);
		logic [16:0]        prod;
		logic signed [15:0] mag;
		prod = 17'(sf_lookup(sfi)) * 17'(quarter_mult(code[2:1])) + 17'd2;
		mag  = signed'({1'b0, prod[16:2]});
		return code[0] ? -mag : mag;
	endfunction

endpackage

// ===== sv/qoa_slice_lms_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// qoa_slice_lms_decoder_unit
// QOA slice decoder with per-channel four-tap LMS predictor state.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode, channel, payload. Mode 0 loads
// the four history values of a channel, mode 1 its four weights (element 0
// in payload[63:48]); both give no output. Mode 2 decodes a 64-bit slice
// word into 20 samples. Mode 3 and channels at or above MAX_CHANNELS are
// dropped.
// Output channel (out_valid / out_stall): sample, out_channel, last; last is
// high on the twentieth sample of a slice.
// A slice takes a state fetch step, then per sample the shared multiplier
// steps (4 taps, one final add, one update), then a write-back step;
// in_stall stays high until the slice is written back, so a new slice is
// accepted only after the previous one. The first sample is presented after
// the fetch, the four taps, the final add and the update. A stalled output
// holds the next sample in the update step, and the multiply steps for the
// sample after it wait until the output is taken.
// Reset clears all channel state to zero and empties the output register.
// ----------------------------------------------------------------------------
module qoa_slice_lms_decoder_unit
	import qsld_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         channel,
	input  logic [63:0]        payload,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic [2:0]         out_channel,
	output logic               last
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_MAC   = 6'b000100,
		ST_SUM   = 6'b001000,
		ST_UPD   = 6'b010000,
		ST_WBACK = 6'b100000
	} state_t;

	state_t             state_q;
	logic [4:0]         idx_q;
	logic [1:0]         tap_q;
	logic               out_valid_q;
	logic signed [15:0] hist_q [4];
	logic signed [15:0] wgt_q [4];
	logic [59:0]        slice_q;
	logic [3:0]         sfi_q;
	logic [2:0]         chan_q;
	logic signed [15:0] r_q;
	logic signed [15:0] out_sample_q;
	logic [2:0]         out_chan_q;
	logic               out_last_q;

	logic                    in_xfer;
	logic                    ch_ok;
	logic                    upd_go;
	logic                    last_idx;
	mac_ctl_t                mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic signed [20:0]      pred;
	logic signed [21:0]      sum;
	logic signed [15:0]      samp;
	logic signed [15:0]      delta;
	logic signed [15:0]      wgt_nxt [4];
	logic                    hist_we;
	logic                    wgt_we;
	logic [CH_W-1:0]         waddr;
	row_t                    hist_wdata;
	row_t                    wgt_wdata;
	row_t                    hist_row;
	row_t                    wgt_row;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign ch_ok    = 32'(channel) < MAX_CHANNELS;
	assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign last_idx = (idx_q == 5'(SLICE_SAMPLES - 1));

	assign hist_we    = (in_xfer && ch_ok && mode == MODE_HIST) || (state_q == ST_WBACK);
	assign wgt_we     = (in_xfer && ch_ok && mode == MODE_WGT) || (state_q == ST_WBACK);
	assign waddr      = (state_q == ST_WBACK) ? CH_W'(chan_q) : CH_W'(channel);
	assign hist_wdata = (state_q == ST_WBACK) ? {hist_q[0], hist_q[1], hist_q[2], hist_q[3]}
	                                          : payload;
	assign wgt_wdata  = (state_q == ST_WBACK) ? {wgt_q[0], wgt_q[1], wgt_q[2], wgt_q[3]}
	                                          : payload;

	qsld_row_mem #(.DEPTH(MAX_CHANNELS), .AW(CH_W)) u_hist_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (hist_we),
		.waddr  (waddr),
		.wdata  (hist_wdata),
		.raddr  (CH_W'(channel)),
		.rdata  (hist_row)
	);

	qsld_row_mem #(.DEPTH(MAX_CHANNELS), .AW(CH_W)) u_wgt_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wgt_we),
		.waddr  (waddr),
		.wdata  (wgt_wdata),
		.raddr  (CH_W'(channel)),
		.rdata  (wgt_row)
	);

	always_comb begin
		mac_ctl.mul = (state_q == ST_MAC);
		mac_ctl.add = ((state_q == ST_MAC) && (tap_q != 2'd0)) || (state_q == ST_SUM);
		mac_ctl.clr = (state_q == ST_MAC) && (tap_q == 2'd1);
	end

	qsld_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (hist_q[tap_q]),
		.b   (wgt_q[tap_q]),
		.acc (acc)
	);

	always_comb begin
		pred  = 21'(acc >>> PRED_SHIFT);
		sum   = 22'(pred) + 22'(r_q);
		if (sum < 22'(SAMPLE_MIN)) begin
			samp = 16'(SAMPLE_MIN);
		end else if (sum > 22'(SAMPLE_MAX)) begin
			samp = 16'(SAMPLE_MAX);
		end else begin
			samp = 16'(sum);
		end
		delta = r_q >>> 4;
		for (int i = 0; i < 4; i++) begin
			wgt_nxt[i] = hist_q[i][15] ? (wgt_q[i] - delta) : (wgt_q[i] + delta);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && ch_ok && mode == MODE_DEC) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					idx_q   <= '0;
					tap_q   <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					tap_q <= tap_q + 2'd1;
					if (tap_q == 2'd3) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						if (last_idx) begin
							state_q <= ST_WBACK;
						end else begin
							idx_q   <= idx_q + 5'd1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_WBACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slice_q <= payload[59:0];
			sfi_q   <= payload[63:60];
			chan_q  <= channel;
		end
		if (state_q == ST_FETCH) begin
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= hist_row[ROW_W-1-16*i -: 16];
				wgt_q[i]  <= wgt_row[ROW_W-1-16*i -: 16];
			end
		end
		if (state_q == ST_MAC && tap_q == 2'd0) begin
			r_q <= dequant(sfi_q, slice_q[59:57]);
		end
		if (upd_go) begin
			for (int i = 0; i < 4; i++) begin
				wgt_q[i] <= wgt_nxt[i];
			end
			hist_q[0]    <= hist_q[1];
			hist_q[1]    <= hist_q[2];
			hist_q[2]    <= hist_q[3];
			hist_q[3]    <= samp;
			slice_q      <= {slice_q[56:0], 3'b000};
			out_sample_q <= samp;
			out_chan_q   <= chan_q;
			out_last_q   <= last_idx;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample      = out_sample_q;
	assign out_channel = out_chan_q;
	assign last        = out_last_q;

	a_dec_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && ch_ok && mode == MODE_DEC) |=> state_q == ST_FETCH)
		else $error("decode transfer did not start a state fetch");

	a_sum_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (tap_q == 2'd0 && $past(state_q) == ST_MAC))
		else $error("final add reached without four taps");

	a_wback_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WBACK) |-> (out_valid && last))
		else $error("write-back without the last sample presented");

endmodule

// ===== sv/qsld_row_mem.sv =====
// ----------------------------------------------------------------------------
// qsld_row_mem
// Per-channel row store of four 16-bit values; rows read as zero until written.
// ----------------------------------------------------------------------------
module qsld_row_mem
	import qsld_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  row_t          wdata,
	input  logic [AW-1:0] raddr,
	output row_t          rdata
);

	row_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	row_t             rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/qsld_mac.sv =====
// ----------------------------------------------------------------------------
// qsld_mac
// Shared 16x16 multiply-accumulate unit for the four-tap predictor.
// ----------------------------------------------------------------------------
module qsld_mac
	import qsld_pkg::*;
(
	input  logic                    clk,
	input  mac_ctl_t                ctl,
	input  logic signed [15:0]      a,
	input  logic signed [15:0]      b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [31:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= a * b;
		end
		if (ctl.add) begin
			acc_q <= (ctl.clr ? '0 : acc_q) + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

// ===== tb/qsld_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsld_sample_checker
// Watches both channels of the QOA slice decoder, predicts the PCM samples
// of every slice from its own copy of the per-channel LMS state and compares
// each output transfer with the oldest sample still due.
// ----------------------------------------------------------------------------
module qsld_sample_checker
	import qsld_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         channel,
	input  logic [63:0]        payload,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] sample,
	input  logic [2:0]         out_channel,
	input  logic               last,
	output int                 fails,
	output int                 pending
);

	typedef struct packed {
		logic signed [15:0] pcm;
		logic [2:0]         chan;
		logic               last;
	} pcm_t;

	localparam int SF_STEP [16] = '{1, 7, 21, 45, 84, 138, 211, 304, 421, 562, 731, 928,
		1157, 1419, 1715, 2048};
	localparam int QUARTER [4] = '{3, 10, 18, 28};

	logic [15:0] hist_mem [MAX_CHANNELS][4];
	logic [15:0] wgt_mem  [MAX_CHANNELS][4];
	pcm_t        pcm_due [$];
	pcm_t        head;
	int          mismatch_cnt;

	function automatic logic signed [15:0] residual_of(input logic [3:0] sfi,
		input logic [2:0] code);
		int mag;
		mag = (SF_STEP[sfi] * QUARTER[code[2:1]] + 2) >> 2;
		return 16'(code[0] ? -mag : mag);
	endfunction

	function automatic void run_lms_slice(input logic [2:0] ch, input logic [63:0] word);
		logic signed [15:0] r;
		logic signed [15:0] delta;
		longint             acc;
		longint             pred;
		int                 s;
		pcm_t               e;
		for (int k = 0; k < SLICE_SAMPLES; k++) begin
			r = residual_of(word[63:60], word[59-3*k -: 3]);
			acc = 0;
			for (int i = 0; i < 4; i++)
				acc += longint'($signed(hist_mem[ch][i])) * longint'($signed(wgt_mem[ch][i]));
			pred = acc >>> PRED_SHIFT;
			s = int'(pred) + int'(r);
			if (s < SAMPLE_MIN)
				s = SAMPLE_MIN;
			else if (s > SAMPLE_MAX)
				s = SAMPLE_MAX;
			delta = r >>> 4;
			for (int i = 0; i < 4; i++) begin
				if (hist_mem[ch][i][15])
					wgt_mem[ch][i] = wgt_mem[ch][i] - 16'(delta);
				else
					wgt_mem[ch][i] = wgt_mem[ch][i] + 16'(delta);
			end
			for (int i = 0; i < 3; i++)
				hist_mem[ch][i] = hist_mem[ch][i+1];
			hist_mem[ch][3] = s[15:0];
			e.pcm  = s[15:0];
			e.chan = ch;
			e.last = (k == SLICE_SAMPLES - 1);
			pcm_due.insert(pcm_due.size(), e);
		end
	endfunction

	function automatic void note_mismatch(input bit was_due, input pcm_t want);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			if (was_due)
				$display("mismatch: got sample %0d ch %0d last %0d, expected %0d ch %0d last %0d",
					sample, out_channel, last, want.pcm, want.chan, want.last);
			else
				$display("mismatch: got sample %0d ch %0d last %0d with nothing due",
					sample, out_channel, last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CHANNELS; c++)
				for (int i = 0; i < 4; i++) begin
					hist_mem[c][i] = '0;
					wgt_mem[c][i]  = '0;
				end
			pcm_due.delete();
			mismatch_cnt = 0;
			fails   <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall && int'(channel) < MAX_CHANNELS) begin
				case (mode)
					MODE_HIST: begin
						for (int i = 0; i < 4; i++)
							hist_mem[channel][i] = payload[63-16*i -: 16];
					end
					MODE_WGT: begin
						for (int i = 0; i < 4; i++)
							wgt_mem[channel][i] = payload[63-16*i -: 16];
					end
					MODE_DEC: run_lms_slice(channel, payload);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pcm_due.size() == 0) begin
					head = '0;
					note_mismatch(1'b0, head);
				end else begin
					head = pcm_due.pop_front();
					if (sample !== head.pcm || out_channel !== head.chan || last !== head.last)
						note_mismatch(1'b1, head);
				end
			end
			fails   <= mismatch_cnt;
			pending <= pcm_due.size();
		end
	end

endmodule

// ===== tb/qoa_slice_lms_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qoa_slice_lms_decoder_unit_test
// Drives history and weight loads, slice words and unused-mode items into
// the QOA slice decoder with random idling on both channels, a long output
// hold-off and a drain pause, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module qoa_slice_lms_decoder_unit_test;
	import qsld_pkg::*;

	localparam int         N_CH        = 8;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic [1:0]         mode      = MODE_HIST;
	logic [2:0]         channel   = 3'd0;
	logic [63:0]        payload   = 64'd0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic signed [15:0] sample;
	logic [2:0]         out_channel;
	logic               last;
	int                 fails;
	int                 pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit long_hold   = 1'b0;

	always #4 clk = ~clk;

	qoa_slice_lms_decoder_unit #(.MAX_CHANNELS(N_CH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .channel(channel), .payload(payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample(sample), .out_channel(out_channel), .last(last)
	);

	qsld_sample_checker #(.MAX_CHANNELS(N_CH)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .channel(channel), .payload(payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample(sample), .out_channel(out_channel), .last(last),
		.fails(fails), .pending(pending)
	);

	initial begin
		#5_000_000;
		$display("qoa_slice_lms_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (int'($urandom_range(99)) < rx_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] slice_word(input logic [3:0] sfi, input logic [2:0] first,
		input bit ramp);
		logic [63:0] w;
		w = '0;
		w[63:60] = sfi;
		for (int k = 0; k < SLICE_SAMPLES; k++)
			w[59-3*k -: 3] = first + (ramp ? 3'(k) : 3'd0);
		return w;
	endfunction

	function automatic logic [63:0] pick_weights();
		logic [63:0] w;
		case ($urandom_range(2))
			0: w = {16'h0000, 16'h0000, 16'hE000, 16'h4000};
			1: begin
				for (int i = 0; i < 4; i++)
					w[63-16*i -: 16] = 16'($urandom_range(32767)) - 16'd16384;
			end
			default: w = rand_word();
		endcase
		return w;
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [2:0] c, input logic [63:0] p);
		if (int'($urandom_range(99)) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		channel  <= c;
		payload  <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_frame(output int n);
		logic [2:0] ch;
		int         count;
		ch = 3'($urandom_range(7));
		send_item(MODE_HIST, ch, ($urandom_range(3) == 0) ? 64'd0 : rand_word());
		send_item(MODE_WGT, ch, pick_weights());
		count = $urandom_range(1, 5);
		repeat (count) send_item(MODE_DEC, ch, rand_word());
		n = count + 2;
	endtask

	task automatic random_single(output int n);
		int pick;
		pick = $urandom_range(99);
		n = 1;
		if (pick < 70)
			send_item(MODE_DEC, 3'($urandom_range(7)), rand_word());
		else if (pick < 80)
			send_item(MODE_HIST, 3'($urandom_range(7)), rand_word());
		else if (pick < 90)
			send_item(MODE_WGT, 3'($urandom_range(7)), pick_weights());
		else begin
			send_item(MODE_UNUSED, 3'($urandom_range(7)), rand_word());
			n = 0;
		end
	endtask

	task automatic run_random(input int count);
		int done;
		int n;
		done = 0;
		while (done < count) begin
			if ($urandom_range(1))
				random_frame(n);
			else
				random_single(n);
			done += n;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_item(MODE_DEC, 3'd0, 64'd0);
		send_item(MODE_DEC, 3'd1, slice_word(4'd0, 3'd0, 1'b1));
		send_item(MODE_DEC, 3'd1, slice_word(4'd15, 3'd0, 1'b1));
		send_item(MODE_DEC, 3'd2, '1);
		send_item(MODE_UNUSED, 3'd5, rand_word());
		send_item(MODE_HIST, 3'd3, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});
		send_item(MODE_WGT, 3'd3, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		send_item(MODE_DEC, 3'd3, slice_word(4'd15, 3'd3, 1'b1));
		send_item(MODE_HIST, 3'd7, {4{16'h7FFF}});
		send_item(MODE_WGT, 3'd7, {4{16'h7FFF}});
		send_item(MODE_DEC, 3'd7, slice_word(4'd15, 3'd6, 1'b0));
		send_item(MODE_HIST, 3'd4, {4{16'h8000}});
		send_item(MODE_WGT, 3'd4, {4{16'h7FFF}});
		send_item(MODE_DEC, 3'd4, slice_word(4'd15, 3'd7, 1'b0));
		send_item(MODE_HIST, 3'd5, 64'd0);
		send_item(MODE_WGT, 3'd5, {16'h0000, 16'h0000, 16'hE000, 16'h4000});
		send_item(MODE_DEC, 3'd5, slice_word(4'd7, 3'd2, 1'b1));
		send_item(MODE_HIST, 3'd6, '1);
		send_item(MODE_WGT, 3'd6, '1);
		send_item(MODE_DEC, 3'd6, slice_word(4'd8, 3'd1, 1'b0));
		send_item(MODE_DEC, 3'd6, rand_word());

		tx_idle_pct = 30;
		rx_idle_pct = 30;
		run_random(90);

		tx_idle_pct = 0;
		long_hold = 1'b1;
		repeat (5) send_item(MODE_DEC, 3'($urandom_range(7)), rand_word());
		wait_drained();

		tx_idle_pct = 10;
		rx_idle_pct = 60;
		run_random(50);
		tx_idle_pct = 60;
		rx_idle_pct = 10;
		run_random(50);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(40);
		in_valid <= 1'b0;

		wait_drained();
		repeat (150) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("qoa_slice_lms_decoder_unit regression: pass");
		else
			$display("qoa_slice_lms_decoder_unit regression: fail");
		$finish;
	end

endmodule
